// ===== hw/rtl/tcce_pkg.sv =====
package tcce_pkg;

	localparam int unsigned COLUMNS   = 80;
	localparam int unsigned ROWS      = 25;
	localparam int unsigned TAB_WIDTH = 8;

	localparam int unsigned ROW_W = 5;
	localparam int unsigned COL_W = 7;
	localparam int unsigned POS_W = 11;
	localparam int unsigned WORD_W = 16;

	localparam logic [WORD_W-1:0] FILL_WORD = 16'h0F20;

	localparam logic [7:0] CHAR_BS = 8'd8;
	localparam logic [7:0] CHAR_HT = 8'd9;
	localparam logic [7:0] CHAR_LF = 8'd10;
	localparam logic [7:0] CHAR_FF = 8'd12;
	localparam logic [7:0] CHAR_CR = 8'd13;
	localparam logic [7:0] CHAR_SPACE = 8'd32;

	localparam logic [1:0] CFG_FG    = 2'd0;
	localparam logic [1:0] CFG_BG    = 2'd1;
	localparam logic [1:0] CFG_BLINK = 2'd2;

	localparam int unsigned FIFO_DEPTH = 4;
	localparam int unsigned FIFO_AW = 2;
	localparam int unsigned FIFO_CW = 3;

	typedef enum logic [1:0] {
		KIND_CELL   = 2'd0,
		KIND_CLEAR  = 2'd1,
		KIND_CURSOR = 2'd2
	} kind_t;

	typedef struct packed {
		kind_t             kind;
		logic [POS_W-1:0]  cell_index;
		logic [WORD_W-1:0] cell_word;
		logic [POS_W-1:0]  cursor_position;
		logic              last;
	} result_t;

	typedef struct packed {
		logic [1:0] n;
		result_t    r0;
		result_t    r1;
	} push_t;

	typedef struct packed {
		logic               not_empty;
		logic               room2;
		logic [FIFO_CW-1:0] count;
	} fifo_status_t;

endpackage

// ===== hw/rtl/tcce_result_fifo.sv =====
module tcce_result_fifo
	import tcce_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  push_t        push,
	input  logic         pop,
	output result_t      head,
	output fifo_status_t status
);

	result_t mem_q [FIFO_DEPTH];
	logic [FIFO_AW-1:0] wp_q;
	logic [FIFO_AW-1:0] rp_q;
	logic [FIFO_CW-1:0] count_q;
	logic [FIFO_AW-1:0] wp_next;

	assign wp_next = wp_q + FIFO_AW'(1);

	always_ff @(posedge clk) begin
		if (push.n != 2'd0) begin
			mem_q[wp_q] <= push.r0;
		end
		if (push.n == 2'd2) begin
			mem_q[wp_next] <= push.r1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q    <= '0;
			rp_q    <= '0;
			count_q <= '0;
		end else begin
			wp_q    <= wp_q + FIFO_AW'(push.n);
			rp_q    <= rp_q + FIFO_AW'(pop);
			count_q <= count_q + FIFO_CW'(push.n) - FIFO_CW'(pop);
		end
	end

	assign head             = mem_q[rp_q];
	assign status.not_empty = (count_q != '0);
	assign status.room2     = (count_q <= FIFO_CW'(FIFO_DEPTH - 2));
	assign status.count     = count_q;

endmodule

// ===== hw/rtl/text_console_cursor_engine_top.sv =====
// text console cursor engine
// s_* takes one character byte per request in s_tdata[7:0]. bytes above 127 give
// nothing, bytes 32 to 127 give one cell write, other bytes give one set-cursor
// request, form feed gives a clear request followed by the set-cursor request.
// m_* carries results: m_tuser is the kind (0 cell write, 1 clear, 2 set cursor),
// m_tdata holds cell_index [10:0], cell_word [26:11], cursor_position [37:27],
// m_tlast marks the final result of a character.
// cfg_* writes a register: index 0 fg_color, 1 bg_color, 2 blink_enable,
// value in cfg_data low bits; other indexes are ignored. cfg_ready is always high.
// a byte taken is held in the input register, and its results are queued when
// that register advances; the queue head is offered on m_*.
// throughput: one byte per cycle while two queue slots are free; a form feed uses
// two slots of the four-entry result queue, so output rate bounds the stream when
// form feeds come often. the input register advances only with two free slots;
// when the receiver stalls the queue fills and s_tready drops, nothing is lost.
// reset clears the cursor to the top-left, the colours to white on black with no
// blink, and empties the queue.
module text_console_cursor_engine_top
	import tcce_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // char_byte
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,   // cell_index, cell_word, cursor_position, zero pad
	output logic        m_tlast,   // last_result
	output logic [1:0]  m_tuser,   // result_kind
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [3:0]  cfg_data
);

	localparam logic [COL_W-1:0] LAST_COL = COL_W'(COLUMNS - 1);
	localparam logic [ROW_W-1:0] LAST_ROW = ROW_W'(ROWS - 1);
	localparam logic [COL_W:0]   TAB_STEP = (COL_W + 1)'(TAB_WIDTH);

	logic [3:0] fg_q;
	logic [2:0] bg_q;
	logic       blink_q;
	logic [ROW_W-1:0] row_q;
	logic [COL_W-1:0] col_q;
	logic [7:0] char_s1;
	logic       valid_s1;
	logic       advance;

	push_t        push;
	result_t      head;
	fifo_status_t status;

	logic [ROW_W-1:0] row_n;
	logic [COL_W-1:0] col_n;
	logic [POS_W-1:0] pos_cur;
	logic [POS_W-1:0] pos_new;
	logic [COL_W:0]   tab_col;
	logic [WORD_W-1:0] char_word;

	assign cfg_ready = 1'b1;
	assign advance   = valid_s1 && status.room2;
	assign s_tready  = !valid_s1 || status.room2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fg_q    <= 4'd15;
			bg_q    <= 3'd0;
			blink_q <= 1'b0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_FG:    fg_q    <= cfg_data;
				CFG_BG:    bg_q    <= cfg_data[2:0];
				CFG_BLINK: blink_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			char_s1 <= s_tdata;
		end
	end

	assign tab_col = (COL_W + 1)'(col_q) + TAB_STEP
		- (COL_W + 1)'(col_q % TAB_WIDTH);

	always_comb begin
		row_n = row_q;
		col_n = col_q;
		if (char_s1[7]) begin
			row_n = row_q;
		end else if (char_s1 >= CHAR_SPACE) begin
			if (col_q >= LAST_COL) begin
				col_n = '0;
				row_n = (row_q >= LAST_ROW) ? '0 : row_q + ROW_W'(1);
			end else begin
				col_n = col_q + COL_W'(1);
			end
		end else begin
			unique case (char_s1)
				CHAR_BS: if (col_q != '0) col_n = col_q - COL_W'(1);
				CHAR_HT: begin
					if (col_q < LAST_COL) begin
						col_n = (tab_col > (COL_W + 1)'(LAST_COL)) ? LAST_COL
							: tab_col[COL_W-1:0];
					end
				end
				CHAR_LF: if (row_q < LAST_ROW) row_n = row_q + ROW_W'(1);
				CHAR_FF: begin
					row_n = '0;
					col_n = '0;
				end
				CHAR_CR: col_n = '0;
				default: ;
			endcase
		end
	end

	assign pos_cur = POS_W'(row_q) * POS_W'(COLUMNS) + POS_W'(col_q);
	assign pos_new = POS_W'(row_n) * POS_W'(COLUMNS) + POS_W'(col_n);
	assign char_word = {blink_q, bg_q, fg_q, char_s1};

	always_comb begin
		push.n  = 2'd0;
		push.r0 = '{kind: KIND_CURSOR, cell_index: '0, cell_word: '0,
			cursor_position: pos_new, last: 1'b1};
		push.r1 = '{kind: KIND_CURSOR, cell_index: '0, cell_word: '0,
			cursor_position: pos_new, last: 1'b1};
		if (advance && !char_s1[7]) begin
			if (char_s1 >= CHAR_SPACE) begin
				push.n  = 2'd1;
				push.r0 = '{kind: KIND_CELL, cell_index: pos_cur, cell_word: char_word,
					cursor_position: '0, last: 1'b1};
			end else if (char_s1 == CHAR_FF) begin
				push.n  = 2'd2;
				push.r0 = '{kind: KIND_CLEAR, cell_index: '0, cell_word: FILL_WORD,
					cursor_position: '0, last: 1'b0};
			end else begin
				push.n = 2'd1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q <= '0;
			col_q <= '0;
		end else if (advance) begin
			row_q <= row_n;
			col_q <= col_n;
		end
	end

	tcce_result_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.pop    (m_tvalid && m_tready),
		.head   (head),
		.status (status)
	);

	assign m_tvalid = status.not_empty;
	assign m_tuser  = head.kind;
	assign m_tlast  = head.last;
	assign m_tdata  = {2'b00, head.cursor_position, head.cell_word, head.cell_index};

	a_cursor_range: assert property (@(posedge clk) disable iff (!arst_n)
		(row_q <= LAST_ROW) && (col_q <= LAST_COL))
		else $error("cursor outside screen");

	a_fifo_bound: assert property (@(posedge clk) disable iff (!arst_n)
		status.count <= FIFO_CW'(FIFO_DEPTH))
		else $error("result queue overflow");

	a_ff_result: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && char_s1 == CHAR_FF) |=> m_tvalid)
		else $error("form feed gave no result");

	a_clear_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser == KIND_CLEAR) |-> !m_tlast)
		else $error("clear request marked last");

endmodule

// ===== dv/tb_text_console_cursor_engine_top.sv =====
module tb_text_console_cursor_engine_top;
	timeunit 1ns;
	timeprecision 1ps;
	import tcce_pkg::*;

	localparam int          PREDICTED   = -1;
	localparam int          HOLD_CYCLES = 120;
	localparam int          DRAIN       = 6;
	localparam int          PHASE_CHARS = 380;
	localparam logic [1:0]  CFG_UNUSED  = 2'd3;
	localparam result_t     NO_R        = '0;

	typedef struct {
		logic [7:0] ch;
		int         n_typed;
		result_t    w0;
		result_t    w1;
	} dir_row_t;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [7:0]  s_tdata;
	logic        m_tvalid;
	logic        m_tready;
	logic [39:0] m_tdata;
	logic        m_tlast;
	logic [1:0]  m_tuser;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [1:0]  cfg_index;
	logic [3:0]  cfg_data;

	// console state as predicted
	int unsigned cur_row;
	int unsigned cur_col;
	logic [3:0]  fg_now;
	logic [2:0]  bg_now;
	logic        blink_now;

	result_t     pending_results[$];
	dir_row_t    directed_rows[18];

	int errors;
	int chars_taken;
	int cells_seen;
	int clears_seen;
	int cursors_seen;
	int corner_wraps;
	int tabs_at_end;
	int settings_used;
	bit tx_gaps;
	bit rx_gaps;
	bit quiet;
	bit hold_off_req;

	text_console_cursor_engine_top DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast),
		.m_tuser   (m_tuser),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial clk = 1'b0;
	always #4 clk = ~clk;

	function automatic result_t cell_r(input int idx, input logic [15:0] w);
		result_t r;
		r.kind            = KIND_CELL;
		r.cell_index      = POS_W'(idx);
		r.cell_word       = w;
		r.cursor_position = '0;
		r.last            = 1'b1;
		return r;
	endfunction

	function automatic result_t cursor_r(input int unsigned pos);
		result_t r;
		r.kind            = KIND_CURSOR;
		r.cell_index      = '0;
		r.cell_word       = '0;
		r.cursor_position = POS_W'(pos);
		r.last            = 1'b1;
		return r;
	endfunction

	function automatic result_t clear_r();
		result_t r;
		r.kind            = KIND_CLEAR;
		r.cell_index      = '0;
		r.cell_word       = 16'h0F20;
		r.cursor_position = '0;
		r.last            = 1'b0;
		return r;
	endfunction

	// advance the console by one byte, returning the results it causes
	function automatic int console_step(input logic [7:0] c, output result_t r0,
			output result_t r1);
		int n;
		n  = 0;
		r0 = NO_R;
		r1 = NO_R;
		if (c > 8'd127)
			return 0;
		if (c >= CHAR_SPACE) begin
			r0 = cell_r(cur_row * COLUMNS + cur_col, {blink_now, bg_now, fg_now, c});
			if (cur_col >= COLUMNS - 1) begin
				cur_col = 0;
				if (cur_row >= ROWS - 1) begin
					cur_row = 0;
					corner_wraps++;
				end else begin
					cur_row++;
				end
			end else begin
				cur_col++;
			end
			return 1;
		end
		case (c)
			CHAR_BS: begin
				if (cur_col != 0)
					cur_col--;
			end
			CHAR_HT: begin
				if (cur_col < COLUMNS - 1) begin
					cur_col++;
					while ((cur_col % TAB_WIDTH) != 0 && cur_col < COLUMNS - 1)
						cur_col++;
				end else begin
					tabs_at_end++;
				end
			end
			CHAR_LF: begin
				if (cur_row < ROWS - 1)
					cur_row++;
			end
			CHAR_FF: begin
				r0      = clear_r();
				n       = 1;
				cur_row = 0;
				cur_col = 0;
			end
			CHAR_CR: begin
				cur_col = 0;
			end
			default: ;
		endcase
		if (n == 0)
			r0 = cursor_r(cur_row * COLUMNS + cur_col);
		else
			r1 = cursor_r(cur_row * COLUMNS + cur_col);
		return n + 1;
	endfunction

	// offer one byte, wait for it to be taken, then queue what it should give
	task automatic push_char(input logic [7:0] c, input int n_typed, input result_t w0,
			input result_t w1);
		bit      ok;
		int      n;
		result_t r0;
		result_t r1;
		if (tx_gaps && !quiet && $urandom_range(0, 5) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 11)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= c;
		do begin
			@(negedge clk);
			ok = s_tready;
			@(posedge clk);
		end while (!ok);
		chars_taken++;
		n = console_step(c, r0, r1);
		if (n_typed != PREDICTED) begin
			n  = n_typed;
			r0 = w0;
			r1 = w1;
		end
		if (n > 0)
			pending_results.push_back(r0);
		if (n > 1)
			pending_results.push_back(r1);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [3:0] val);
		bit ok;
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do begin
			@(negedge clk);
			ok = cfg_ready;
			@(posedge clk);
		end while (!ok);
		case (idx)
			CFG_FG:    fg_now    = val;
			CFG_BG:    bg_now    = val[2:0];
			CFG_BLINK: blink_now = val[0];
			default: ;
		endcase
	endtask

	task automatic set_colours(input logic [3:0] f, input logic [3:0] b,
			input logic [3:0] k, input bit poke_unused);
		write_reg(CFG_FG, f);
		write_reg(CFG_BG, b);
		write_reg(CFG_BLINK, k);
		if (poke_unused)
			write_reg(CFG_UNUSED, 4'($urandom_range(0, 15)));
		cfg_valid <= 1'b0;
		settings_used++;
	endtask

	task automatic settle();
		s_tvalid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN) @(posedge clk);
	endtask

	// well-formed runs of text and cursor motion, with some raw noise
	task automatic run_random(input int budget);
		logic [7:0] seg[$];
		int         counted;
		int         pick;
		int         len;
		counted = 0;
		while (counted < budget) begin
			seg.delete();
			pick    = $urandom_range(0, 99);
			tx_gaps = ($urandom_range(0, 3) != 0);
			if (pick < 40) begin
				len = $urandom_range(1, 90);
				repeat (len) seg.push_back(8'($urandom_range(32, 127)));
			end else if (pick < 55) begin
				len = $urandom_range(1, 30);
				repeat (len) seg.push_back(CHAR_LF);
			end else if (pick < 65) begin
				len = $urandom_range(1, 12);
				repeat (len) seg.push_back(CHAR_HT);
			end else if (pick < 73) begin
				len = $urandom_range(1, 10);
				repeat (len) seg.push_back(CHAR_BS);
			end else if (pick < 81) begin
				seg.push_back(CHAR_CR);
				if ($urandom_range(0, 1))
					seg.push_back(CHAR_LF);
			end else if (pick < 86) begin
				seg.push_back(CHAR_FF);
			end else if (pick < 93) begin
				seg.push_back(8'($urandom_range(0, 31)));
			end else begin
				len = $urandom_range(1, 8);
				repeat (len) seg.push_back(8'($urandom_range(0, 255)));
			end
			foreach (seg[i]) begin
				push_char(seg[i], PREDICTED, NO_R, NO_R);
				if (seg[i] <= 8'd127)
					counted++;
			end
		end
	endtask

	task automatic check_field(input string name, input int want, input int got);
		if (want != got) begin
			errors++;
			$display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
		end
	endtask

	// results are sampled mid-cycle, the request completes at the next rising edge
	always @(negedge clk) begin
		result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			case (m_tuser)
				KIND_CELL:   cells_seen++;
				KIND_CLEAR:  clears_seen++;
				KIND_CURSOR: cursors_seen++;
				default: ;
			endcase
			if (pending_results.size() == 0) begin
				errors++;
				$display("%0t: unexpected result, expected none, actual kind %0d data 0x%0h",
					$time, m_tuser, m_tdata);
			end else begin
				want = pending_results.pop_front();
				check_field("result_kind", want.kind, m_tuser);
				check_field("cell_index", want.cell_index, m_tdata[10:0]);
				check_field("cell_word", want.cell_word, m_tdata[26:11]);
				check_field("cursor_position", want.cursor_position, m_tdata[37:27]);
				check_field("last_result", want.last, m_tlast);
			end
		end
	end

	// output side: random stalls, calm stretches, one long hold-off
	initial begin
		m_tready = 1'b0;
		rx_gaps  = 1'b1;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if ($urandom_range(0, 49) == 0)
				rx_gaps = !rx_gaps;
			if (hold_off_req) begin
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_off_req = 1'b0;
				m_tready <= 1'b1;
			end else if (rx_gaps && !quiet && $urandom_range(0, 4) == 0) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(1, 11)) @(posedge clk);
				m_tready <= 1'b1;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	initial begin
		#4_000_000;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	initial begin
		int wait_cycles;
		arst_n       = 1'b0;
		s_tvalid     = 1'b0;
		s_tdata      = '0;
		cfg_valid    = 1'b0;
		cfg_index    = '0;
		cfg_data     = '0;
		cur_row      = 0;
		cur_col      = 0;
		fg_now       = 4'd15;
		bg_now       = 3'd0;
		blink_now    = 1'b0;
		errors       = 0;
		chars_taken  = 0;
		cells_seen   = 0;
		clears_seen  = 0;
		cursors_seen = 0;
		corner_wraps = 0;
		tabs_at_end  = 0;
		settings_used = 1;
		tx_gaps      = 1'b1;
		quiet        = 1'b0;
		hold_off_req = 1'b0;

		directed_rows = '{
			'{8'h41,   1,         cell_r(0, 16'h0F41), NO_R},
			'{8'h80,   0,         NO_R,                NO_R},
			'{8'hFF,   0,         NO_R,                NO_R},
			'{8'h20,   PREDICTED, NO_R,                NO_R},
			'{8'h7F,   PREDICTED, NO_R,                NO_R},
			'{8'h5A,   PREDICTED, NO_R,                NO_R},
			'{CHAR_BS, PREDICTED, NO_R,                NO_R},
			'{CHAR_CR, 1,         cursor_r(0),         NO_R},
			'{CHAR_BS, 1,         cursor_r(0),         NO_R},
			'{CHAR_HT, PREDICTED, NO_R,                NO_R},
			'{CHAR_HT, PREDICTED, NO_R,                NO_R},
			'{CHAR_LF, PREDICTED, NO_R,                NO_R},
			'{8'h00,   PREDICTED, NO_R,                NO_R},
			'{8'h1F,   PREDICTED, NO_R,                NO_R},
			'{8'h0B,   PREDICTED, NO_R,                NO_R},
			'{8'h61,   PREDICTED, NO_R,                NO_R},
			'{CHAR_FF, 2,         clear_r(),           cursor_r(0)},
			'{8'h55,   1,         cell_r(0, 16'h0F55), NO_R}
		};

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset colours, edge bytes and each handled control code
		foreach (directed_rows[i])
			push_char(directed_rows[i].ch, directed_rows[i].n_typed, directed_rows[i].w0,
				directed_rows[i].w1);
		settle();

		set_colours(4'd0, 4'd7, 4'd1, 1'b1);
		run_random(PHASE_CHARS);
		settle();

		// background write with the top bit set, masked to black
		set_colours(4'd15, 4'd8, 4'd0, 1'b0);
		hold_off_req = 1'b1;
		run_random(PHASE_CHARS);
		settle();

		repeat (2) begin
			set_colours(4'($urandom_range(0, 15)), 4'($urandom_range(0, 7)),
				4'($urandom_range(0, 1)), 1'b0);
			run_random(PHASE_CHARS);
			settle();
		end

		set_colours(4'($urandom_range(0, 15)), 4'($urandom_range(0, 7)),
			4'($urandom_range(0, 1)), 1'b0);
		quiet = 1'b1;
		run_random(PHASE_CHARS);
		s_tvalid <= 1'b0;

		wait_cycles = 0;
		while (pending_results.size() != 0 && wait_cycles < 2000) begin
			@(posedge clk);
			wait_cycles++;
		end
		repeat (DRAIN) @(posedge clk);
		if (pending_results.size() != 0) begin
			errors += pending_results.size();
			$display("%0t: %0d results never arrived, expected kind %0d first", $time,
				pending_results.size(), pending_results[0].kind);
		end

		$display("run: %0d bytes under %0d colour settings gave %0d cell writes, %0d clears, %0d cursor updates",
			chars_taken, settings_used, cells_seen, clears_seen, cursors_seen);
		$display("run: %0d corner wraps to the top-left, %0d tabs at the line end, one long output hold-off",
			corner_wraps, tabs_at_end);
		if (errors == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

// ===== text_console_cursor_engine_top.f =====
hw/rtl/tcce_pkg.sv
hw/rtl/tcce_result_fifo.sv
hw/rtl/text_console_cursor_engine_top.sv
dv/tb_text_console_cursor_engine_top.sv
